// ===== rtl/backward_flag_scan_unit_macros.svh =====
// Assertion macros shared by the backward flag scan unit.
`ifndef BACKWARD_FLAG_SCAN_UNIT_MACROS_SVH
`define BACKWARD_FLAG_SCAN_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFS_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("bfs: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BFS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("bfs: next-cycle check failed");

`endif

// ===== rtl/bfs_pkg.sv =====
// Package: widths, operation codes and control structs of the flag scan unit.
`timescale 1ns / 1ps
`default_nettype none
package bfs_pkg;

  localparam int unsigned MAX_POSITIONS_DEF = 65536;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 17;
  localparam int unsigned BOUND_W = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned SIZE_W  = 17;
  localparam int unsigned FPOS_W  = 16;
  localparam int unsigned FLAG_W  = 3;

  localparam logic [OP_W-1:0] OP_WRITE         = 3'd0;
  localparam logic [OP_W-1:0] OP_NEAREST_SETA  = 3'd1;
  localparam logic [OP_W-1:0] OP_NEAREST_INSTR = 3'd2;
  localparam logic [OP_W-1:0] OP_NTH_INSTR     = 3'd3;
  localparam logic [OP_W-1:0] OP_NEAREST_BOUND = 3'd4;
  localparam logic [OP_W-1:0] OP_NTH_BOUND     = 3'd5;

  // bit positions inside one flag store entry
  localparam int unsigned FLAG_INSTR = 0;
  localparam int unsigned FLAG_PROC  = 1;
  localparam int unsigned FLAG_SETA  = 2;

  typedef struct packed {
    logic clear_step;    // write zero at the clear pointer and advance it
    logic load;          // take the request: latch scan setup, store a write
    logic step;          // move the scan one position down
    logic finish;        // register the result and strobe it
    logic finish_found;  // result carries a hit
  } cmd_t;

  typedef struct packed {
    logic clear_last;    // clear pointer is at the last entry
    logic empty;         // latched request scans nothing
    logic hit;           // entry under scan matches
    logic stop;          // entry under scan ends the search
    logic at_low;        // scan reached its lower bound
  } status_t;

endpackage
`default_nettype wire

// ===== rtl/backward_flag_scan_unit.sv =====
// Top level: backward flag scan unit, controller plus datapath.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// in_operation selects a flag write (0) or one of five backward queries
// (1..5); every request yields exactly one result, shown on out_found and
// out_found_position for a single cycle while out_valid is high. The
// receiver cannot stall, so results must be taken as they appear.
// A write, an unused code or a query that scans nothing strobes its result
// straight after the setup state. A query first reads its start entry in
// the setup state, then examines positions from there downward; the scan
// walks one flag memory entry per cycle through the registered read port, so
// busy drops with the strobe and the next request may be taken in that cycle.
// cfg_we/cfg_wdata load code_size at any edge out of reset, with no
// handshake; change it only while no query is in flight.
// Reset: rst_n is synchronous, active low. After release the unit clears the
// flag memory, all MAX_POSITIONS entries at one entry per cycle, holding busy
// high; code_size resets to zero.
`timescale 1ns / 1ps
`default_nettype none
`include "backward_flag_scan_unit_macros.svh"
module backward_flag_scan_unit #(
  parameter int unsigned MAX_POSITIONS = bfs_pkg::MAX_POSITIONS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [bfs_pkg::OP_W-1:0]      in_operation,
  input  wire logic [bfs_pkg::POS_W-1:0]     in_position,
  input  wire logic [bfs_pkg::BOUND_W-1:0]   in_lower_bound,
  input  wire logic [bfs_pkg::COUNT_W-1:0]   in_match_count,
  input  wire logic                          in_is_instruction,
  input  wire logic                          in_is_proc_start,
  input  wire logic                          in_sets_a,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [bfs_pkg::FPOS_W-1:0]         out_found_position,
  input  wire logic                          cfg_we,
  input  wire logic [bfs_pkg::SIZE_W-1:0]    cfg_wdata
);
  import bfs_pkg::*;

  cmd_t    cmd;
  status_t status;

  bfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  bfs_datapath #(
    .MAX_POSITIONS (MAX_POSITIONS)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_operation       (in_operation),
    .in_position        (in_position),
    .in_lower_bound     (in_lower_bound),
    .in_match_count     (in_match_count),
    .in_is_instruction  (in_is_instruction),
    .in_is_proc_start   (in_is_proc_start),
    .in_sets_a          (in_sets_a),
    .out_found          (out_found),
    .out_found_position (out_found_position)
  );

  // a taken request always occupies the unit for at least the next cycle
  `BFS_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
  // results only appear once the unit has gone idle
  `BFS_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_valid, !busy)
  `BFS_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `BFS_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_found, out_found_position == '0)
  // a finish never coincides with a scan step or a load
  `BFS_ASSERT_NOW(a_finish_no_step, clk, rst_n, cmd.finish, !cmd.step && !cmd.load)

endmodule
`default_nettype wire

// ===== rtl/bfs_ctrl.sv =====
// Controller: clearing pass, request intake and the backward scan sequence.
`timescale 1ns / 1ps
`default_nettype none
module bfs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire bfs_pkg::status_t status,
  output bfs_pkg::cmd_t         cmd,
  output logic                  busy,
  output logic                  out_valid
);
  import bfs_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        // first read is issued here; data is ready in ST_SCAN
        if (status.empty) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (status.hit) begin
          cmd.finish       = 1'b1;
          cmd.finish_found = 1'b1;
          state_nxt        = ST_IDLE;
        end else if (status.stop || status.at_low) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.finish;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/bfs_datapath.sv =====
// Datapath: flag memory, code size register, scan pointer, count and result.
`timescale 1ns / 1ps
`default_nettype none
module bfs_datapath #(
  parameter int unsigned MAX_POSITIONS = bfs_pkg::MAX_POSITIONS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bfs_pkg::cmd_t                 cmd,
  output bfs_pkg::status_t                   status,
  input  wire logic                          cfg_we,
  input  wire logic [bfs_pkg::SIZE_W-1:0]    cfg_wdata,
  input  wire logic [bfs_pkg::OP_W-1:0]      in_operation,
  input  wire logic [bfs_pkg::POS_W-1:0]     in_position,
  input  wire logic [bfs_pkg::BOUND_W-1:0]   in_lower_bound,
  input  wire logic [bfs_pkg::COUNT_W-1:0]   in_match_count,
  input  wire logic                          in_is_instruction,
  input  wire logic                          in_is_proc_start,
  input  wire logic                          in_sets_a,
  output logic                               out_found,
  output logic [bfs_pkg::FPOS_W-1:0]         out_found_position
);
  import bfs_pkg::*;

  localparam int unsigned AW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
  // compare width: holds the port values and MAX_POSITIONS itself
  localparam int unsigned CW = (AW + 1 > POS_W) ? AW + 1 : POS_W;
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_POSITIONS);
  localparam logic [AW-1:0] LAST_A = AW'(MAX_POSITIONS - 1);

  logic [FLAG_W-1:0]  mem [MAX_POSITIONS];
  logic [FLAG_W-1:0]  rdata_r;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      clr_r;
  logic [SIZE_W-1:0]  code_size_r;
  logic [OP_W-1:0]    op_r;
  logic [AW-1:0]      pos_r;
  logic [AW-1:0]      low_r;
  logic [COUNT_W-1:0] cnt_r;
  logic               empty_r;
  logic               found_r;
  logic [FPOS_W-1:0]  fpos_r;

  logic [CW-1:0] pos_ext, size_ext, last_ext, lim_ext, first_ext, low_ext, res_ext;
  logic          is_query, is_bounded, is_nth, no_start, empty_calc;
  logic          wr_item;
  logic          f_instr, f_proc, f_seta, cnt_one;

  // scan setup from the request fields
  always_comb begin
    pos_ext    = CW'(in_position);
    size_ext   = (CW'(code_size_r) > MAX_C) ? MAX_C : CW'(code_size_r);
    no_start   = (pos_ext == '0) || (size_ext == '0);
    last_ext   = pos_ext - CW'(1);
    lim_ext    = size_ext - CW'(1);
    first_ext  = (last_ext > lim_ext) ? lim_ext : last_ext;
    is_query   = (in_operation == OP_NEAREST_SETA) || (in_operation == OP_NEAREST_INSTR) ||
                 (in_operation == OP_NTH_INSTR) || (in_operation == OP_NEAREST_BOUND) ||
                 (in_operation == OP_NTH_BOUND);
    is_bounded = (in_operation == OP_NEAREST_BOUND) || (in_operation == OP_NTH_BOUND);
    is_nth     = (in_operation == OP_NTH_INSTR) || (in_operation == OP_NTH_BOUND);
    low_ext    = is_bounded ? CW'(in_lower_bound) : '0;
    empty_calc = !is_query || no_start || (first_ext < low_ext) ||
                 (is_nth && (in_match_count == '0));
    wr_item    = cmd.load && (in_operation == OP_WRITE) && (pos_ext < MAX_C);
  end

  // next read goes one below the current position when the scan steps
  assign rd_addr = cmd.step ? (pos_r - AW'(1)) : pos_r;

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_r] <= '0;
    end else if (wr_item) begin
      mem[pos_ext[AW-1:0]] <= {in_sets_a, in_is_proc_start, in_is_instruction};
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      code_size_r <= '0;
    end else begin
      if (cmd.clear_step) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cfg_we) begin
        code_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_operation;
      pos_r   <= first_ext[AW-1:0];
      low_r   <= low_ext[AW-1:0];
      cnt_r   <= in_match_count;
      empty_r <= empty_calc;
    end else if (cmd.step) begin
      pos_r <= pos_r - AW'(1);
      if (f_instr) begin
        cnt_r <= cnt_r - COUNT_W'(1);
      end
    end
    if (cmd.finish) begin
      found_r <= cmd.finish_found;
      fpos_r  <= cmd.finish_found ? res_ext[FPOS_W-1:0] : '0;
    end
  end

  assign res_ext = CW'(pos_r);

  // match and stop rules per mode
  always_comb begin
    f_instr = rdata_r[FLAG_INSTR];
    f_proc  = rdata_r[FLAG_PROC];
    f_seta  = rdata_r[FLAG_SETA];
    cnt_one = (cnt_r == COUNT_W'(1));
    status.hit  = 1'b0;
    status.stop = 1'b0;
    unique case (op_r)
      OP_NEAREST_SETA: begin
        status.stop = f_instr && f_proc;
        status.hit  = f_instr && !f_proc && f_seta;
      end
      OP_NEAREST_INSTR, OP_NEAREST_BOUND: begin
        status.hit  = f_instr;
        status.stop = f_proc;
      end
      OP_NTH_INSTR: begin
        status.hit  = f_instr && cnt_one;
        status.stop = f_proc;
      end
      OP_NTH_BOUND: begin
        status.hit  = f_instr && cnt_one;
      end
      default: begin
        status.stop = 1'b1;
      end
    endcase
    status.clear_last = (clr_r == LAST_A);
    status.empty      = empty_r;
    status.at_low     = (pos_r == low_r);
  end

  assign out_found          = found_r;
  assign out_found_position = fpos_r;

endmodule
`default_nettype wire
